/* src/assert_macros.svh */
// Assertion macros shared by the parser modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that an expression holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Checks that a condition implies a consequence in the same cycle.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that a condition implies a consequence in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/hcp_pkg.sv */
// Package with the shared types, constants and functions of the hex command parser.
`timescale 1ns / 1ps

package hcp_pkg;

    localparam int KEPT_NYBBLES = 7;
    localparam int QUEUE_DEPTH  = 2;
    localparam int QUEUE_PTR_W  = 1;
    localparam int QUEUE_CNT_W  = QUEUE_PTR_W + 1;

    localparam logic [7:0] TERMINATOR_RESET = 8'd10;
    localparam logic [3:0] SOLID_CODE_RESET = 4'd0;

    typedef enum logic [0:0] {
        CFG_TERMINATOR = 1'b0,
        CFG_SOLID_CODE = 1'b1
    } cfg_index_t;

    typedef enum logic [0:0] {
        TOK_DIGIT = 1'b0,
        TOK_TERM  = 1'b1
    } tok_kind_t;

    typedef struct packed {
        tok_kind_t  kind;
        logic [3:0] nybble;
    } token_t;

    typedef struct packed {
        logic [7:0] terminator;
        logic [3:0] solid_code;
    } cfg_t;

    typedef struct packed {
        logic is_hex;
        logic [3:0] nybble;
    } hex_t;

    function automatic hex_t decode_hex(input logic [7:0] b);
        hex_t r;
        r.is_hex = 1'b0;
        r.nybble = 4'd0;
        if (b >= 8'h30 && b <= 8'h39)
        begin
            r.is_hex = 1'b1;
            r.nybble = 4'(b - 8'h30);
        end
        else if (b >= 8'h61 && b <= 8'h66)
        begin
            r.is_hex = 1'b1;
            r.nybble = 4'(b - 8'h57);
        end
        else if (b >= 8'h41 && b <= 8'h46)
        begin
            r.is_hex = 1'b1;
            r.nybble = 4'(b - 8'h37);
        end
        return r;
    endfunction

endpackage

/* src/hcp_front.sv */
// Front end: accepts received bytes and turns them into digit and terminator tokens.
`timescale 1ns / 1ps

module hcp_front
    import hcp_pkg::*;
(
    input  logic [7:0] rx_byte,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] terminator,
    input  logic       q_full,
    output logic       push,
    output token_t     push_token
);

    hex_t hex;
    logic is_term;

    assign hex     = decode_hex(rx_byte);
    assign is_term = (rx_byte == terminator);

    assign in_ready = !q_full;

    // Bytes that are neither terminator nor hex digit are dropped here.
    assign push = in_valid && !q_full && (is_term || hex.is_hex);

    always_comb
    begin
        push_token.kind   = is_term ? TOK_TERM : TOK_DIGIT;
        push_token.nybble = hex.nybble;
    end

endmodule

/* src/hcp_queue.sv */
// Two-entry token queue between the front end and the line assembler.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module hcp_queue
    import hcp_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  token_t push_token,
    output logic   full,
    input  logic   pop,
    output logic   head_valid,
    output token_t head_token
);

    token_t                 ent_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_token = ent_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wr_ptr_reg] <= push_token;
        end
    end

    `ASSERT_IMPLIES(a_no_push_full, push, !full, "token pushed into a full queue")
    `ASSERT_IMPLIES(a_no_pop_empty, pop, head_valid, "token popped from an empty queue")
    `ASSERT_ALWAYS(a_count_range, count_reg <= QUEUE_CNT_W'(QUEUE_DEPTH), "queue count overflow")

endmodule

/* src/hcp_back.sv */
// Back end: assembles the line from tokens and registers the finished command item.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module hcp_back
    import hcp_pkg::*;
#(
    parameter int LINE_DEPTH = 32
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [3:0] solid_code,
    input  logic       head_valid,
    input  token_t     head_token,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [3:0] command_type,
    output logic [5:0] line_length,
    output logic       color_valid,
    output logic [7:0] red_level,
    output logic [7:0] green_level,
    output logic [7:0] blue_level
);

    logic [5:0] count_reg, count_next;
    logic [3:0] nyb_reg [KEPT_NYBBLES];
    logic       out_valid_reg, out_valid_next;
    logic [3:0] type_reg;
    logic [5:0] len_reg;
    logic       color_reg;
    logic [7:0] red_reg, green_reg, blue_reg;
    logic       slot_free;
    logic       is_term;
    logic       emit;
    logic       store_nyb;
    logic       color_ok;
    logic       color_shown;

    assign slot_free = !out_valid_reg || out_ready;
    assign is_term   = (head_token.kind == TOK_TERM);
    assign pop       = head_valid && (!is_term || slot_free);
    assign emit      = pop && is_term && (count_reg != '0);
    assign store_nyb = pop && !is_term && (count_reg < 6'(KEPT_NYBBLES));
    assign color_ok  = (nyb_reg[0] == solid_code) && (count_reg >= 6'(KEPT_NYBBLES));

    always_comb
    begin
        count_next = count_reg;
        if (pop)
        begin
            if (is_term || count_reg == 6'(LINE_DEPTH))
            begin
                count_next = '0;
            end
            else
            begin
                count_next = count_reg + 6'd1;
            end
        end
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (store_nyb)
        begin
            nyb_reg[count_reg[2:0]] <= head_token.nybble;
        end
        if (emit)
        begin
            type_reg  <= nyb_reg[0];
            len_reg   <= count_reg;
            color_reg <= color_ok;
            red_reg   <= color_ok ? {nyb_reg[1], nyb_reg[2]} : 8'd0;
            green_reg <= color_ok ? {nyb_reg[3], nyb_reg[4]} : 8'd0;
            blue_reg  <= color_ok ? {nyb_reg[5], nyb_reg[6]} : 8'd0;
        end
    end

    assign out_valid    = out_valid_reg;
    assign command_type = type_reg;
    assign line_length  = len_reg;
    assign color_valid  = color_reg;
    assign red_level    = red_reg;
    assign green_level  = green_reg;
    assign blue_level   = blue_reg;

    assign color_shown = out_valid_reg && color_reg;

    `ASSERT_ALWAYS(a_count_bound, count_reg <= 6'(LINE_DEPTH), "digit count past line depth")
    `ASSERT_IMPLIES(a_color_len, color_shown, len_reg >= 6'(KEPT_NYBBLES), "short color line")
    `ASSERT_NEXT(a_emit_shows, emit, out_valid_reg && len_reg != '0, "emitted item not shown")

endmodule

/* src/hex_command_line_parser.sv */
// Top level of the hex command line parser with its configuration registers.
//
//  Channel   Signals                                   Moves
//  input     in_valid, in_ready, rx_byte               one received byte per item
//  output    out_valid, out_ready, command fields      at most one command item per line
//  config    cfg_we, cfg_index, cfg_data               register writes, no read-back
//
// One byte is accepted per cycle while the two-entry token queue has room.
// With the output free, a command item is registered when its terminator is popped from the queue head.
// Reset sets the terminator to line feed, the solid color code to zero and the count to zero.
// Only a terminator at the queue head waits for a held output; the tokens behind it fill
// the queue, and then in_ready drops until the output item is taken.

`timescale 1ns / 1ps

module hex_command_line_parser
    import hcp_pkg::*;
#(
    parameter int LINE_DEPTH = 32
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [0:0] cfg_index,
    input  logic [7:0] cfg_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [3:0] command_type,
    output logic [5:0] line_length,
    output logic       color_valid,
    output logic [7:0] red_level,
    output logic [7:0] green_level,
    output logic [7:0] blue_level
);

    cfg_t   cfg_reg, cfg_next;
    logic   q_full;
    logic   push;
    token_t push_token;
    logic   pop;
    logic   head_valid;
    token_t head_token;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_TERMINATOR: cfg_next.terminator = cfg_data;
                CFG_SOLID_CODE: cfg_next.solid_code = cfg_data[3:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.terminator <= TERMINATOR_RESET;
            cfg_reg.solid_code <= SOLID_CODE_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    hcp_front u_front (
        .rx_byte    (rx_byte),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .terminator (cfg_reg.terminator),
        .q_full     (q_full),
        .push       (push),
        .push_token (push_token)
    );

    hcp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_token (push_token),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_token (head_token)
    );

    hcp_back #(
        .LINE_DEPTH (LINE_DEPTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .solid_code   (cfg_reg.solid_code),
        .head_valid   (head_valid),
        .head_token   (head_token),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .command_type (command_type),
        .line_length  (line_length),
        .color_valid  (color_valid),
        .red_level    (red_level),
        .green_level  (green_level),
        .blue_level   (blue_level)
    );

endmodule

/* tb/sv/tb_hex_command_line_parser.sv */
// Self-checking testbench for the hex command line parser: directed lines, random lines, stalls.
`timescale 1ns / 1ps

module tb_hex_command_line_parser;
    import hcp_pkg::*;

    localparam int CLK_PERIOD   = 8;
    localparam int LINE_DEPTH   = 32;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        logic [3:0] command_type;
        logic [5:0] line_length;
        logic       color_valid;
        logic [7:0] red_level;
        logic [7:0] green_level;
        logic [7:0] blue_level;
    } command_t;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cfg_we;
    cfg_index_t cfg_index;
    logic [7:0] cfg_data;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] rx_byte;
    logic       out_valid;
    logic       out_ready;
    logic [3:0] command_type;
    logic [5:0] line_length;
    logic       color_valid;
    logic [7:0] red_level;
    logic [7:0] green_level;
    logic [7:0] blue_level;

    logic [7:0] term_char;
    logic [3:0] solid_code;
    logic [5:0] digit_count;
    logic [3:0] kept_nybbles [KEPT_NYBBLES];
    command_t   pending_commands [$];
    int         parsed_items;
    int         error_count;
    int         hold_cycles;
    bit         tx_gaps_on;
    bit         rx_gaps_on;

    hex_command_line_parser #(.LINE_DEPTH(LINE_DEPTH)) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .command_type (command_type),
        .line_length  (line_length),
        .color_valid  (color_valid),
        .red_level    (red_level),
        .green_level  (green_level),
        .blue_level   (blue_level)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic int draw_gap(input bit enabled);
        return enabled ? $urandom_range(0, 10) : 0;
    endfunction

    function automatic void parse_rx_byte(input logic [7:0] b);
        command_t   cmd;
        logic [3:0] nyb;
        bit         is_hex;
        is_hex = 1'b0;
        nyb = 4'd0;
        if (b == term_char)
        begin
            parsed_items++;
            if (digit_count > 0)
            begin
                cmd.command_type = kept_nybbles[0];
                cmd.line_length  = digit_count;
                cmd.color_valid  = (kept_nybbles[0] == solid_code) &&
                                   (digit_count >= KEPT_NYBBLES);
                cmd.red_level    = cmd.color_valid ? {kept_nybbles[1], kept_nybbles[2]} : 8'd0;
                cmd.green_level  = cmd.color_valid ? {kept_nybbles[3], kept_nybbles[4]} : 8'd0;
                cmd.blue_level   = cmd.color_valid ? {kept_nybbles[5], kept_nybbles[6]} : 8'd0;
                pending_commands.push_back(cmd);
            end
            digit_count = 6'd0;
            return;
        end
        if (b >= 8'h30 && b <= 8'h39)
        begin
            is_hex = 1'b1;
            nyb = b[3:0];
        end
        else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46))
        begin
            is_hex = 1'b1;
            nyb = b[3:0] + 4'd9;
        end
        if (is_hex)
        begin
            parsed_items++;
            if (digit_count >= LINE_DEPTH)
                digit_count = 6'd0;
            else
            begin
                if (digit_count < KEPT_NYBBLES)
                    kept_nybbles[digit_count] = nyb;
                digit_count = digit_count + 6'd1;
            end
        end
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10)
            return 8'h30 + 8'(n);
        return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + 8'(n - 4'd10);
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = draw_gap(tx_gaps_on);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        do
            @(posedge clk);
        while (!in_ready);
        parse_rx_byte(b);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    task automatic send_line(input int len, input bit with_term);
        logic [3:0] n;
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                send_byte(8'($urandom_range(0, 255)));
            n = (i == 0 && $urandom_range(0, 1)) ? solid_code : 4'($urandom_range(0, 15));
            send_byte(hex_char(n));
        end
        if (with_term)
            send_byte(term_char);
    endtask

    task automatic end_burst();
        in_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        end_burst();
        while (pending_commands.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_config(input logic [7:0] term, input logic [7:0] code_raw);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_TERMINATOR;
        cfg_data  <= term;
        @(posedge clk);
        term_char = term;
        cfg_index <= CFG_SOLID_CODE;
        cfg_data  <= code_raw;
        @(posedge clk);
        solid_code = code_raw[3:0];
        cfg_we <= 1'b0;
    endtask

    task automatic send_random_lines(input int items);
        int target;
        int r;
        int len;
        target = parsed_items + items;
        while (parsed_items < target)
        begin
            r = $urandom_range(0, 99);
            if (r < 5)
                len = 0;
            else if (r < 70)
                len = $urandom_range(1, 9);
            else if (r < 88)
                len = $urandom_range(10, 31);
            else if (r < 95)
                len = LINE_DEPTH;
            else
                len = $urandom_range(LINE_DEPTH + 1, LINE_DEPTH + 4);
            send_line(len, $urandom_range(0, 9) != 0);
        end
    endtask

    task automatic test_reset_defaults();
        send_text("\n");
        send_byte(8'h00);
        send_byte(8'hFF);
        send_text("\n");
        send_text("0fFFfFf\n");
        send_text("0000000\n");
        send_text("F\n");
    endtask

    task automatic test_line_limits();
        send_line(LINE_DEPTH, 1'b1);
        send_line(LINE_DEPTH + 1, 1'b0);
        send_line(2, 1'b1);
    endtask

    task automatic test_random_lines();
        send_random_lines(80);
    endtask

    task automatic test_back_pressure();
        tx_gaps_on = 1'b0;
        hold_cycles = 200;
        send_random_lines(50);
        tx_gaps_on = 1'b1;
    endtask

    task automatic test_sender_pause();
        send_random_lines(20);
        wait_idle();
        send_random_lines(20);
    endtask

    task automatic test_config_sweep();
        wait_idle();
        write_config(8'd13, 8'd15);
        send_random_lines(40);
        wait_idle();
        tx_gaps_on = 1'b0;
        rx_gaps_on = 1'b0;
        write_config(8'd0, 8'd7);
        send_random_lines(40);
        wait_idle();
        tx_gaps_on = 1'b1;
        rx_gaps_on = 1'b1;
        write_config(8'd255, 8'hF5);
        send_random_lines(40);
    endtask

    task automatic test_hex_terminator();
        wait_idle();
        write_config(8'h37, 8'd3);
        send_text("3a7");
        send_text("3ABCDEF7");
        send_random_lines(30);
        wait_idle();
        write_config(TERMINATOR_RESET, 8'(SOLID_CODE_RESET));
        send_random_lines(30);
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= CFG_TERMINATOR;
        cfg_data  <= 8'd0;
        in_valid  <= 1'b0;
        rx_byte   <= 8'd0;
        term_char = TERMINATOR_RESET;
        solid_code = SOLID_CODE_RESET;
        digit_count = 6'd0;
        parsed_items = 0;
        error_count = 0;
        hold_cycles = 0;
        tx_gaps_on = 1'b1;
        rx_gaps_on = 1'b1;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_reset_defaults();
        test_line_limits();
        test_random_lines();
        test_back_pressure();
        test_sender_pause();
        test_config_sweep();
        test_hex_terminator();

        end_burst();
        for (int i = 0; i < 2000 && pending_commands.size() > 0; i++)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        error_count += pending_commands.size();
        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        int       gap;
        command_t got;
        command_t want;
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_cycles > 0)
            begin
                gap = hold_cycles;
                hold_cycles = 0;
            end
            else
                gap = draw_gap(rx_gaps_on);
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (out_valid !== 1'b1);
            got = {command_type, line_length, color_valid, red_level, green_level, blue_level};
            if (pending_commands.size() == 0)
            begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("unexpected item: type %h len %0d color %b rgb %h %h %h",
                             got.command_type, got.line_length, got.color_valid,
                             got.red_level, got.green_level, got.blue_level);
            end
            else
            begin
                want = pending_commands.pop_front();
                if (got !== want)
                begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                    begin
                        $display("mismatch: expected type %h len %0d color %b rgb %h %h %h",
                                 want.command_type, want.line_length, want.color_valid,
                                 want.red_level, want.green_level, want.blue_level);
                        $display("          got      type %h len %0d color %b rgb %h %h %h",
                                 got.command_type, got.line_length, got.color_valid,
                                 got.red_level, got.green_level, got.blue_level);
                    end
                end
            end
        end
    end

    initial
    begin
        #4_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+src
src/hcp_pkg.sv
src/hcp_front.sv
src/hcp_queue.sv
src/hcp_back.sv
src/hex_command_line_parser.sv
tb/sv/tb_hex_command_line_parser.sv
